// ----- hw/rtl/mse_pkg.sv -----
`timescale 1ns / 1ps

package mse_pkg;

    localparam int DATA_WORDS = 1024;
    localparam int DM_AW      = $clog2(DATA_WORDS);
    localparam int REG_COUNT  = 32;
    localparam int RF_AW      = $clog2(REG_COUNT);
    localparam int MIDX_W     = 10;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CFG_AW      = 3;
    localparam int CFG_SEL_BIT = 2;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 120;
    localparam int RES_BITS    = 114;
    localparam int M_PAD_W     = M_TDATA_W - RES_BITS;

    localparam logic [31:0] DATA_BASE_RST = 32'h1000_0000;
    localparam logic [31:0] START_PC_RST  = 32'h0040_0000;

    // register select
    localparam logic REG_DATA_BASE = 1'b0;
    localparam logic REG_START_PC  = 1'b1;

    // request kind
    localparam logic KIND_PRELOAD = 1'b0;
    localparam logic KIND_EXEC    = 1'b1;

    localparam logic [RF_AW-1:0] RA_INDEX = RF_AW'(31);

    // opcodes
    localparam logic [5:0] OPC_SPECIAL = 6'h00;
    localparam logic [5:0] OPC_J       = 6'h02;
    localparam logic [5:0] OPC_JAL     = 6'h03;
    localparam logic [5:0] OPC_BEQ     = 6'h04;
    localparam logic [5:0] OPC_BNE     = 6'h05;
    localparam logic [5:0] OPC_ADDIU   = 6'h09;
    localparam logic [5:0] OPC_SLTIU   = 6'h0B;
    localparam logic [5:0] OPC_ANDI    = 6'h0C;
    localparam logic [5:0] OPC_ORI     = 6'h0D;
    localparam logic [5:0] OPC_LUI     = 6'h0F;
    localparam logic [5:0] OPC_LB      = 6'h20;
    localparam logic [5:0] OPC_LW      = 6'h23;
    localparam logic [5:0] OPC_SB      = 6'h28;
    localparam logic [5:0] OPC_SW      = 6'h2B;

    // r-type function codes
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    typedef logic [FIFO_AW:0] fifo_cnt_t;
    typedef logic [FIFO_AW+1:0] fill_t;

    localparam fifo_cnt_t FIFO_FULL = fifo_cnt_t'(FIFO_DEPTH);
    localparam fifo_cnt_t FIFO_ONE  = fifo_cnt_t'(1);

    typedef struct packed {
        logic              addr_error;
        logic [31:0]       mem_value;
        logic [MIDX_W-1:0] mem_index;
        logic              mem_write;
        logic [31:0]       reg_value;
        logic [RF_AW-1:0]  reg_index;
        logic              reg_write;
        logic [31:0]       next_pc;
    } result_t;

endpackage

// ----- hw/rtl/mips_subset_execute.sv -----
// channel   role     carries                          handshake
// s_*       slave    one request: preload or execute  s_tvalid & s_tready
// m_*       master   one result per request           m_tvalid & m_tready
// apb       slave    data_base, start_pc              psel & penable & pwrite
//
// one request per cycle while s_tready is high; each result is registered through stage 1, stage 2 and the result queue
// stages: register file read, execute and data memory read, memory/reg write back
// register file and data memory are synchronous-read memories with bypass
// a 4-entry result queue absorbs m_tready stalls; s_tready drops when it could fill
// reset clears register file valid bits at once, no clearing pass; pc = start_pc
`timescale 1ns / 1ps

module mips_subset_execute (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mse_pkg::CFG_AW-1:0]       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // instr_word, load_index, load_word
    input  logic [mse_pkg::S_TDATA_W-1:0]    s_tdata,
    // op
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // next_pc, reg_write, reg_index, reg_value, mem_write, mem_index,
    // mem_value, addr_error
    output logic [mse_pkg::M_TDATA_W-1:0]    m_tdata
);
    import mse_pkg::*;

    // configuration
    logic        cfg_wr;
    logic [31:0] data_base_reg;
    logic [31:0] start_pc_reg;
    logic [31:0] pc_reg;

    // request fields
    logic             accept;
    logic [31:0]      in_instr;
    logic [9:0]       in_lidx;
    logic [31:0]      in_lword;
    logic [RF_AW-1:0] in_rs;
    logic [RF_AW-1:0] in_rt;
    logic [31:0]      in_k;

    // register file
    logic [31:0]          rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_vld_reg;
    logic [31:0]          rf_a_reg;
    logic [31:0]          rf_b_reg;
    logic                 rf_a_ok_reg;
    logic                 rf_b_ok_reg;
    logic                 rf_we;

    // data memory
    logic [31:0]      data_mem [DATA_WORDS];
    logic [31:0]      dm_q_reg;
    logic             dm_we;

    // write-back bypass
    logic             rwb_vld_reg;
    logic [RF_AW-1:0] rwb_idx_reg;
    logic [31:0]      rwb_val_reg;
    logic             mwb_vld_reg;
    logic [DM_AW-1:0] mwb_idx_reg;
    logic [31:0]      mwb_val_reg;

    // stage 1
    logic             s1_vld_reg;
    logic             s1_op_reg;
    logic [31:0]      s1_iw_reg;
    logic [9:0]       s1_lidx_reg;
    logic [31:0]      s1_lword_reg;
    logic [31:0]      s1_k_reg;
    logic [5:0]       s1_opc;
    logic [RF_AW-1:0] s1_rs;
    logic [RF_AW-1:0] s1_rt;
    logic [RF_AW-1:0] s1_rd;
    logic [4:0]       s1_sh;
    logic [5:0]       s1_fn;
    logic [31:0]      s1_simm;
    logic [31:0]      s1_zimm;
    logic [31:0]      op_a;
    logic [31:0]      op_b;
    logic [31:0]      s1_off;
    logic             s1_in_range;
    logic [DM_AW-1:0] s1_widx;
    logic             s1_lidx_ok;
    logic [31:0]      pc4;
    logic [31:0]      br_tgt;
    logic [31:0]      jmp_tgt;
    logic [31:0]      s1_npc;
    logic             s1_rw;
    logic [RF_AW-1:0] s1_ridx;
    logic [31:0]      s1_alu;
    logic             s1_load;
    logic             s1_bsel;
    logic             s1_mw;
    logic [DM_AW-1:0] s1_midx;
    logic             s1_err;
    logic [31:0]      s1_sdata;

    // stage 2
    logic             s2_vld_reg;
    logic [31:0]      s2_npc_reg;
    logic             s2_rw_reg;
    logic [RF_AW-1:0] s2_ridx_reg;
    logic [31:0]      s2_alu_reg;
    logic             s2_load_reg;
    logic             s2_bsel_reg;
    logic             s2_mw_reg;
    logic [DM_AW-1:0] s2_midx_reg;
    logic [1:0]       s2_lane_reg;
    logic [31:0]      s2_sdata_reg;
    logic             s2_err_reg;
    logic [31:0]      dm_word;
    logic [7:0]       ld_byte;
    logic [31:0]      ld_val;
    logic [31:0]      st_merge;
    logic [31:0]      s2_rval;
    logic [31:0]      s2_mval;

    // result queue
    result_t   res;
    result_t   out_res;
    fifo_cnt_t fifo_level;
    fill_t     fill;

    // apb
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[CFG_SEL_BIT])
            REG_DATA_BASE: prdata = data_base_reg;
            REG_START_PC:  prdata = start_pc_reg;
            default:       prdata = data_base_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_base_reg <= DATA_BASE_RST;
            start_pc_reg  <= START_PC_RST;
            pc_reg        <= START_PC_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[CFG_SEL_BIT] == REG_START_PC)
            begin
                start_pc_reg <= pwdata;
                pc_reg       <= pwdata;
            end
            else
            begin
                data_base_reg <= pwdata;
            end
        end
        else if (s1_vld_reg)
        begin
            pc_reg <= s1_npc;
        end
    end

    // request side
    assign in_instr = s_tdata[31:0];
    assign in_lidx  = s_tdata[41:32];
    assign in_lword = s_tdata[73:42];
    assign in_rs    = in_instr[25:21];
    assign in_rt    = in_instr[20:16];
    assign in_k     = {{16{in_instr[15]}}, in_instr[15:0]} - data_base_reg;

    assign fill = fill_t'(fifo_level) + fill_t'(s1_vld_reg) + fill_t'(s2_vld_reg);
    assign s_tready = (fill < fill_t'(FIFO_DEPTH));
    assign accept   = s_tvalid && s_tready;

    // register file, read at request acceptance
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[s2_ridx_reg] <= s2_rval;
        end
        rf_a_reg    <= rf_mem[in_rs];
        rf_b_reg    <= rf_mem[in_rt];
        rf_a_ok_reg <= rf_vld_reg[in_rs];
        rf_b_ok_reg <= rf_vld_reg[in_rt];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg  <= '0;
            rwb_vld_reg <= 1'b0;
            mwb_vld_reg <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
        end
        else
        begin
            if (rf_we)
            begin
                rf_vld_reg[s2_ridx_reg] <= 1'b1;
            end
            rwb_vld_reg <= rf_we;
            mwb_vld_reg <= dm_we;
            s1_vld_reg  <= accept;
            s2_vld_reg  <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg    <= s_tuser;
        s1_iw_reg    <= in_instr;
        s1_lidx_reg  <= in_lidx;
        s1_lword_reg <= in_lword;
        s1_k_reg     <= in_k;
        rwb_idx_reg  <= s2_ridx_reg;
        rwb_val_reg  <= s2_rval;
        mwb_idx_reg  <= s2_midx_reg;
        mwb_val_reg  <= s2_mval;
    end

    // stage 1: operands, execute, data address
    assign s1_opc  = s1_iw_reg[31:26];
    assign s1_rs   = s1_iw_reg[25:21];
    assign s1_rt   = s1_iw_reg[20:16];
    assign s1_rd   = s1_iw_reg[15:11];
    assign s1_sh   = s1_iw_reg[10:6];
    assign s1_fn   = s1_iw_reg[5:0];
    assign s1_simm = {{16{s1_iw_reg[15]}}, s1_iw_reg[15:0]};
    assign s1_zimm = {16'h0000, s1_iw_reg[15:0]};

    always_comb
    begin
        if (s2_vld_reg && s2_rw_reg && (s2_ridx_reg == s1_rs))
            op_a = s2_rval;
        else if (rwb_vld_reg && (rwb_idx_reg == s1_rs))
            op_a = rwb_val_reg;
        else if (rf_a_ok_reg)
            op_a = rf_a_reg;
        else
            op_a = '0;

        if (s2_vld_reg && s2_rw_reg && (s2_ridx_reg == s1_rt))
            op_b = s2_rval;
        else if (rwb_vld_reg && (rwb_idx_reg == s1_rt))
            op_b = rwb_val_reg;
        else if (rf_b_ok_reg)
            op_b = rf_b_reg;
        else
            op_b = '0;
    end

    assign s1_off      = op_a + s1_k_reg;
    assign s1_in_range = (s1_off[31:DM_AW+2] == '0);
    assign s1_widx     = s1_off[DM_AW+1:2];
    assign s1_lidx_ok  = (32'(s1_lidx_reg) < 32'(DATA_WORDS));
    assign pc4         = pc_reg + 32'd4;
    assign br_tgt      = pc4 + {s1_simm[29:0], 2'b00};
    assign jmp_tgt     = {pc4[31:28], s1_iw_reg[25:0], 2'b00};

    always_comb
    begin
        s1_npc   = pc4;
        s1_rw    = 1'b0;
        s1_ridx  = s1_rt;
        s1_alu   = '0;
        s1_load  = 1'b0;
        s1_bsel  = 1'b0;
        s1_mw    = 1'b0;
        s1_midx  = '0;
        s1_err   = 1'b0;
        s1_sdata = op_b;
        if (s1_op_reg == KIND_PRELOAD)
        begin
            s1_npc   = pc_reg;
            s1_sdata = s1_lword_reg;
            if (s1_lidx_ok)
            begin
                s1_mw   = 1'b1;
                s1_midx = DM_AW'(s1_lidx_reg);
            end
            else
            begin
                s1_err = 1'b1;
            end
        end
        else
        begin
            unique case (s1_opc) inside
                OPC_SPECIAL:
                begin
                    s1_ridx = s1_rd;
                    s1_rw   = 1'b1;
                    unique case (s1_fn)
                        FN_ADDU: s1_alu = op_a + op_b;
                        FN_AND:  s1_alu = op_a & op_b;
                        FN_NOR:  s1_alu = ~(op_a | op_b);
                        FN_OR:   s1_alu = op_a | op_b;
                        FN_SLTU: s1_alu = {31'd0, (op_a < op_b)};
                        FN_SLL:  s1_alu = op_b << s1_sh;
                        FN_SRL:  s1_alu = op_b >> s1_sh;
                        FN_SUBU: s1_alu = op_a - op_b;
                        FN_JR:
                        begin
                            s1_npc = op_a;
                            s1_rw  = 1'b0;
                        end
                        default: s1_rw = 1'b0;
                    endcase
                end
                OPC_J:
                begin
                    s1_npc = jmp_tgt;
                end
                OPC_JAL:
                begin
                    s1_npc  = jmp_tgt;
                    s1_rw   = 1'b1;
                    s1_ridx = RA_INDEX;
                    s1_alu  = pc4;
                end
                OPC_ADDIU:
                begin
                    s1_rw  = 1'b1;
                    s1_alu = op_a + s1_simm;
                end
                OPC_ANDI:
                begin
                    s1_rw  = 1'b1;
                    s1_alu = op_a & s1_zimm;
                end
                OPC_ORI:
                begin
                    s1_rw  = 1'b1;
                    s1_alu = op_a | s1_zimm;
                end
                OPC_LUI:
                begin
                    s1_rw  = 1'b1;
                    s1_alu = {s1_iw_reg[15:0], 16'h0000};
                end
                OPC_SLTIU:
                begin
                    s1_rw  = 1'b1;
                    s1_alu = {31'd0, (op_a < s1_simm)};
                end
                OPC_BEQ:
                begin
                    if (op_a == op_b)
                        s1_npc = br_tgt;
                end
                OPC_BNE:
                begin
                    if (op_a != op_b)
                        s1_npc = br_tgt;
                end
                OPC_LB, OPC_LW:
                begin
                    if (s1_in_range)
                    begin
                        s1_rw   = 1'b1;
                        s1_load = 1'b1;
                        s1_bsel = (s1_opc == OPC_LB);
                        s1_midx = s1_widx;
                    end
                    else
                    begin
                        s1_err = 1'b1;
                    end
                end
                OPC_SB, OPC_SW:
                begin
                    if (s1_in_range)
                    begin
                        s1_mw   = 1'b1;
                        s1_bsel = (s1_opc == OPC_SB);
                        s1_midx = s1_widx;
                    end
                    else
                    begin
                        s1_err = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            // r0 stays zero
            if (s1_ridx == '0)
                s1_rw = 1'b0;
        end
    end

    // data memory, read issued from stage 1, written back in stage 2
    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            data_mem[s2_midx_reg] <= s2_mval;
        end
        dm_q_reg <= data_mem[s1_widx];
    end

    always_ff @(posedge clk)
    begin
        s2_npc_reg   <= s1_npc;
        s2_rw_reg    <= s1_rw;
        s2_ridx_reg  <= s1_ridx;
        s2_alu_reg   <= s1_alu;
        s2_load_reg  <= s1_load;
        s2_bsel_reg  <= s1_bsel;
        s2_mw_reg    <= s1_mw;
        s2_midx_reg  <= s1_midx;
        s2_lane_reg  <= s1_off[1:0];
        s2_sdata_reg <= s1_sdata;
        s2_err_reg   <= s1_err;
    end

    // stage 2: load data, byte merge, write back
    assign dm_word = (mwb_vld_reg && (mwb_idx_reg == s2_midx_reg)) ? mwb_val_reg : dm_q_reg;

    always_comb
    begin
        case (s2_lane_reg)
            2'd0:
            begin
                ld_byte  = dm_word[31:24];
                st_merge = {s2_sdata_reg[7:0], dm_word[23:0]};
            end
            2'd1:
            begin
                ld_byte  = dm_word[23:16];
                st_merge = {dm_word[31:24], s2_sdata_reg[7:0], dm_word[15:0]};
            end
            2'd2:
            begin
                ld_byte  = dm_word[15:8];
                st_merge = {dm_word[31:16], s2_sdata_reg[7:0], dm_word[7:0]};
            end
            default:
            begin
                ld_byte  = dm_word[7:0];
                st_merge = {dm_word[31:8], s2_sdata_reg[7:0]};
            end
        endcase
    end

    assign ld_val  = s2_bsel_reg ? {{24{ld_byte[7]}}, ld_byte} : dm_word;
    assign s2_rval = s2_load_reg ? ld_val : s2_alu_reg;
    assign s2_mval = s2_bsel_reg ? st_merge : s2_sdata_reg;
    assign rf_we   = s2_vld_reg && s2_rw_reg;
    assign dm_we   = s2_vld_reg && s2_mw_reg;

    always_comb
    begin
        res.next_pc    = s2_npc_reg;
        res.reg_write  = s2_rw_reg;
        res.reg_index  = s2_rw_reg ? s2_ridx_reg : '0;
        res.reg_value  = s2_rw_reg ? s2_rval : '0;
        res.mem_write  = s2_mw_reg;
        res.mem_index  = MIDX_W'(s2_midx_reg);
        res.mem_value  = s2_mw_reg ? s2_mval : '0;
        res.addr_error = s2_err_reg;
    end

    mse_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_vld_reg),
        .push_data (res),
        .pop_valid (m_tvalid),
        .pop_ready (m_tready),
        .pop_data  (out_res),
        .level     (fifo_level)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, out_res.addr_error, out_res.mem_value,
                      out_res.mem_index, out_res.mem_write, out_res.reg_value,
                      out_res.reg_index, out_res.reg_write, out_res.next_pc};

`ifndef SYNTHESIS
    a_r0_never_written: assert property (@(posedge clk) disable iff (!rst_n)
        !rf_vld_reg[0])
        else $error("register zero marked written");

    a_fault_no_side_effect: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_vld_reg && s2_err_reg) |-> (!s2_rw_reg && !s2_mw_reg))
        else $error("faulted access wrote state");

    a_pc_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_vld_reg && !cfg_wr) |=> $stable(pc_reg))
        else $error("pc moved without a request");
`endif

endmodule

// ----- hw/rtl/mse_out_fifo.sv -----
`timescale 1ns / 1ps

module mse_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mse_pkg::result_t  push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output mse_pkg::result_t  pop_data,
    output mse_pkg::fifo_cnt_t level
);
    import mse_pkg::*;

    result_t            q_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    fifo_cnt_t          cnt_reg;
    fifo_cnt_t          cnt_next;
    logic               pop;

    assign pop_valid = (cnt_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = q_mem[rd_ptr_reg];
    assign level     = cnt_reg;

    always_comb
    begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + FIFO_ONE;
            2'b01:   cnt_next = cnt_reg - FIFO_ONE;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((cnt_reg != FIFO_FULL) || pop))
        else $error("result queue overflow");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + FIFO_ONE))
        else $error("result queue count lost a push");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FIFO_FULL)
        else $error("result queue count out of range");
`endif

endmodule

// ----- bench/tb_mips_subset_execute.sv -----
`timescale 1ns / 1ps

module tb_mips_subset_execute;
    import mse_pkg::*;

    localparam int PLAN        = 0;
    localparam int CHECK       = 1;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 150;

    localparam logic [5:0] RTYPE_FNS [9] = '{FN_ADDU, FN_AND, FN_NOR, FN_OR, FN_SLTU,
                                            FN_SLL, FN_SRL, FN_SUBU, FN_JR};
    localparam logic [5:0] IALU_OPS [5] = '{OPC_ADDIU, OPC_ANDI, OPC_ORI, OPC_LUI,
                                           OPC_SLTIU};

    typedef struct packed {
        logic              op;
        logic [31:0]       instr;
        logic [MIDX_W-1:0] lidx;
        logic [31:0]       lword;
    } req_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [CFG_AW-1:0]       paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata = '0;
    logic                    s_tuser = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;

    // architectural state: one copy for stimulus planning, one for checking
    logic [31:0] gpr [2][REG_COUNT] = '{default: '0};
    logic [31:0] dmem [2][DATA_WORDS] = '{default: '0};
    bit          filled [2][DATA_WORDS] = '{default: 1'b0};
    logic [31:0] dbase [2] = '{DATA_BASE_RST, DATA_BASE_RST};
    logic [31:0] pcr [2] = '{START_PC_RST, START_PC_RST};

    req_t    req_q [$];
    result_t effect_q [$];
    req_t    cur_req;

    int send_idle = 35;
    int recv_idle = 75;
    int accepted_cnt = 0;
    int pushed_cnt = 0;
    int hold_left = 0;
    bit hold_used = 1'b0;
    int err_cnt = 0;
    int shown = 0;
    int cycles = 0;

    mips_subset_execute dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t execute_req(input int m, input req_t rq);
        result_t          r;
        logic [5:0]       opc;
        logic [5:0]       fn;
        logic [4:0]       rs;
        logic [4:0]       rt;
        logic [4:0]       sh;
        logic [4:0]       dst;
        logic [31:0]      a;
        logic [31:0]      b;
        logic [31:0]      simm;
        logic [31:0]      zimm;
        logic [31:0]      off;
        logic [31:0]      val;
        logic [DM_AW-1:0] wi;
        logic [4:0]       lane;
        logic [7:0]       bv;
        logic             in_mem;
        logic             wr;
        r = '0;
        if (rq.op == KIND_PRELOAD)
        begin
            if (rq.lidx < DATA_WORDS)
            begin
                dmem[m][rq.lidx] = rq.lword;
                filled[m][rq.lidx] = 1'b1;
                r.mem_write = 1'b1;
                r.mem_index = rq.lidx;
                r.mem_value = rq.lword;
            end
            else
                r.addr_error = 1'b1;
            r.next_pc = pcr[m];
            return r;
        end
        opc = rq.instr[31:26];
        rs = rq.instr[25:21];
        rt = rq.instr[20:16];
        sh = rq.instr[10:6];
        fn = rq.instr[5:0];
        a = gpr[m][rs];
        b = gpr[m][rt];
        simm = {{16{rq.instr[15]}}, rq.instr[15:0]};
        zimm = {16'h0, rq.instr[15:0]};
        off = a + simm - dbase[m];
        in_mem = (off >> 2) < DATA_WORDS;
        wi = off[DM_AW+1:2];
        // big-endian lanes: byte offset 0 sits in bits 31..24
        lane = {~off[1:0], 3'b000};
        wr = 1'b0;
        dst = rt;
        val = '0;
        pcr[m] = pcr[m] + 32'd4;
        case (opc)
            OPC_SPECIAL:
            begin
                dst = rq.instr[15:11];
                wr = 1'b1;
                case (fn)
                    FN_ADDU: val = a + b;
                    FN_AND:  val = a & b;
                    FN_NOR:  val = ~(a | b);
                    FN_OR:   val = a | b;
                    FN_SLTU: val = {31'b0, a < b};
                    FN_SLL:  val = b << sh;
                    FN_SRL:  val = b >> sh;
                    FN_SUBU: val = a - b;
                    FN_JR:
                    begin
                        pcr[m] = a;
                        wr = 1'b0;
                    end
                    default: wr = 1'b0;
                endcase
            end
            OPC_J, OPC_JAL:
            begin
                if (opc == OPC_JAL)
                begin
                    wr = 1'b1;
                    dst = RA_INDEX;
                    val = pcr[m];
                end
                pcr[m] = {pcr[m][31:28], rq.instr[25:0], 2'b00};
            end
            OPC_ADDIU:
            begin
                wr = 1'b1;
                val = a + simm;
            end
            OPC_ANDI:
            begin
                wr = 1'b1;
                val = a & zimm;
            end
            OPC_ORI:
            begin
                wr = 1'b1;
                val = a | zimm;
            end
            OPC_LUI:
            begin
                wr = 1'b1;
                val = {rq.instr[15:0], 16'h0};
            end
            OPC_SLTIU:
            begin
                wr = 1'b1;
                val = {31'b0, a < simm};
            end
            OPC_BEQ:
                if (a == b)
                    pcr[m] = pcr[m] + (simm << 2);
            OPC_BNE:
                if (a != b)
                    pcr[m] = pcr[m] + (simm << 2);
            OPC_LB, OPC_LW:
            begin
                if (!in_mem)
                    r.addr_error = 1'b1;
                else
                begin
                    wr = 1'b1;
                    r.mem_index = MIDX_W'(wi);
                    if (opc == OPC_LW)
                        val = dmem[m][wi];
                    else
                    begin
                        bv = 8'(dmem[m][wi] >> lane);
                        val = {{24{bv[7]}}, bv};
                    end
                end
            end
            OPC_SB, OPC_SW:
            begin
                if (!in_mem)
                    r.addr_error = 1'b1;
                else
                begin
                    if (opc == OPC_SW)
                        r.mem_value = b;
                    else
                        r.mem_value = (dmem[m][wi] & ~(32'hFF << lane))
                                    | ({24'h0, b[7:0]} << lane);
                    dmem[m][wi] = r.mem_value;
                    filled[m][wi] = 1'b1;
                    r.mem_write = 1'b1;
                    r.mem_index = MIDX_W'(wi);
                end
            end
            default: ;
        endcase
        // r0 is hardwired
        if (wr && dst != 5'd0)
        begin
            gpr[m][dst] = val;
            r.reg_write = 1'b1;
            r.reg_index = dst;
            r.reg_value = val;
        end
        r.next_pc = pcr[m];
        return r;
    endfunction

    // true when the word would be read before anything was written there
    function automatic bit reads_blank(input logic [31:0] iw);
        logic [5:0]  opc;
        logic [31:0] off;
        opc = iw[31:26];
        off = gpr[PLAN][iw[25:21]] + {{16{iw[15]}}, iw[15:0]} - dbase[PLAN];
        if (opc != OPC_LB && opc != OPC_LW && opc != OPC_SB)
            return 1'b0;
        return (off >> 2) < DATA_WORDS && !filled[PLAN][off[DM_AW+1:2]];
    endfunction

    function automatic void push_req(input req_t rq);
        if (rq.op == KIND_EXEC && reads_blank(rq.instr))
            rq.instr[31:26] = OPC_SW;
        void'(execute_req(PLAN, rq));
        req_q.push_back(rq);
        pushed_cnt++;
    endfunction

    function automatic logic [31:0] enc_r(input logic [5:0] fn, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [4:0] rd,
                                          input logic [4:0] sh);
        return {OPC_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] opc, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {opc, rs, rt, imm};
    endfunction

    function automatic logic [31:0] enc_j(input logic [5:0] opc, input logic [25:0] tgt);
        return {opc, tgt};
    endfunction

    function automatic req_t exec_req(input logic [31:0] iw);
        req_t rq;
        rq.op = KIND_EXEC;
        rq.instr = iw;
        rq.lidx = MIDX_W'($urandom);
        rq.lword = $urandom;
        return rq;
    endfunction

    function automatic req_t preload_req(input logic [MIDX_W-1:0] idx,
                                         input logic [31:0] word);
        req_t rq;
        rq.op = KIND_PRELOAD;
        rq.instr = $urandom;
        rq.lidx = idx;
        rq.lword = word;
        return rq;
    endfunction

    function automatic logic [4:0] rand_reg();
        return 5'($urandom);
    endfunction

    function automatic logic [4:0] ptr_reg();
        return 5'($urandom_range(1, 4));
    endfunction

    // most traffic stays in a small window so loads find written words
    function automatic logic [MIDX_W-1:0] hot_index();
        if ($urandom_range(99) < 80)
            return MIDX_W'($urandom_range(31));
        return MIDX_W'($urandom_range(DATA_WORDS - 1));
    endfunction

    function automatic logic [31:0] pick_target();
        int pick;
        pick = $urandom_range(99);
        if (pick < 85)
            return dbase[PLAN] + 32'(hot_index()) * 4 + 32'($urandom_range(3));
        if (pick < 95)
            return dbase[PLAN] + 32'(DATA_WORDS + $urandom_range(63)) * 4;
        return $urandom;
    endfunction

    task automatic gen_phase(input int n);
        int          made;
        int          pick;
        logic [4:0]  p;
        logic [31:0] target;
        logic [15:0] imm;
        logic [5:0]  opc;
        logic [5:0]  fn;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                push_req(preload_req(hot_index(), $urandom));
            else if (pick < 20)
            begin
                // pointer setup: lui then ori
                p = ptr_reg();
                target = pick_target();
                push_req(exec_req(enc_i(OPC_LUI, rand_reg(), p, target[31:16])));
                push_req(exec_req(enc_i(OPC_ORI, p, p, target[15:0])));
                made++;
            end
            else if (pick < 50)
            begin
                case ($urandom_range(3))
                    0: opc = OPC_LB;
                    1: opc = OPC_LW;
                    2: opc = OPC_SB;
                    default: opc = OPC_SW;
                endcase
                if ($urandom_range(7) == 0)
                    imm = 16'($urandom);
                else
                    imm = 16'($urandom_range(64) - 32);
                push_req(exec_req(enc_i(opc, ptr_reg(), rand_reg(), imm)));
            end
            else if (pick < 70)
            begin
                fn = ($urandom_range(9) == 0) ? 6'($urandom) : RTYPE_FNS[$urandom_range(8)];
                push_req(exec_req(enc_r(fn, rand_reg(), rand_reg(), rand_reg(),
                                        5'($urandom))));
            end
            else if (pick < 85)
                push_req(exec_req(enc_i(IALU_OPS[$urandom_range(4)], rand_reg(),
                                        rand_reg(), 16'($urandom))));
            else if (pick < 95)
            begin
                case ($urandom_range(3))
                    0: push_req(exec_req(enc_j(OPC_J, 26'($urandom))));
                    1: push_req(exec_req(enc_j(OPC_JAL, 26'($urandom))));
                    2: push_req(exec_req(enc_i($urandom_range(1) ? OPC_BEQ : OPC_BNE,
                                               rand_reg(), rand_reg(), 16'($urandom))));
                    default: push_req(exec_req(enc_r(FN_JR, rand_reg(), 5'd0, 5'd0,
                                                     5'd0)));
                endcase
            end
            else
                push_req(exec_req($urandom));
            made++;
        end
    endtask

    task automatic write_cfg(input logic sel, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_AW'(sel) << CFG_SEL_BIT;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        for (int m = 0; m < 2; m++)
        begin
            if (sel == REG_DATA_BASE)
                dbase[m] = value;
            else
                pcr[m] = value;
        end
    endtask

    task automatic drain();
        while (accepted_cnt != pushed_cnt)
            @(posedge clk);
        while (effect_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic string fmt_res(input result_t r);
        return $sformatf("pc=%h rw=%b ri=%0d rv=%h mw=%b mi=%0d mv=%h err=%b",
                         r.next_pc, r.reg_write, r.reg_index, r.reg_value,
                         r.mem_write, r.mem_index, r.mem_value, r.addr_error);
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                effect_q.push_back(execute_req(CHECK, cur_req));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    cur_req = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= S_TDATA_W'({cur_req.lword, cur_req.lidx, cur_req.instr});
                    s_tuser <= cur_req.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, once
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if (!hold_used && accepted_cnt >= HOLD_AFTER)
            begin
                hold_left <= HOLD_CYCLES;
                hold_used <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end

    // result monitor
    always @(posedge clk)
    begin : mon
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[RES_BITS-1:0];
            if (effect_q.size() == 0)
            begin
                err_cnt++;
                if (shown < 10)
                    $display("unexpected result: %s", fmt_res(got));
                shown++;
            end
            else
            begin
                want = effect_q.pop_front();
                if (got.next_pc !== want.next_pc || got.reg_write !== want.reg_write
                    || got.reg_index !== want.reg_index || got.reg_value !== want.reg_value
                    || got.mem_write !== want.mem_write || got.mem_index !== want.mem_index
                    || got.mem_value !== want.mem_value
                    || got.addr_error !== want.addr_error)
                begin
                    err_cnt++;
                    if (shown < 10)
                    begin
                        $display("mismatch expected: %s", fmt_res(want));
                        $display("         actual:   %s", fmt_res(got));
                    end
                    shown++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: default config, base register r1
        push_req(preload_req(10'd0, 32'h80FF_7F01));
        push_req(preload_req(10'd1023, 32'hA5A5_5A5A));
        push_req(exec_req(enc_i(OPC_LUI, 5'd0, 5'd1, 16'h1000)));
        push_req(exec_req(enc_i(OPC_LW, 5'd1, 5'd2, 16'h0000)));
        push_req(exec_req(enc_i(OPC_LB, 5'd1, 5'd3, 16'h0000)));
        push_req(exec_req(enc_i(OPC_LB, 5'd1, 5'd4, 16'h0003)));
        push_req(exec_req(enc_i(OPC_SB, 5'd1, 5'd2, 16'h0001)));
        push_req(exec_req(enc_i(OPC_SW, 5'd1, 5'd3, 16'h0004)));
        // unaligned word read of the top word, a word read just past the end, then a word store below base
        push_req(exec_req(enc_i(OPC_LW, 5'd1, 5'd5, 16'h0FFE)));
        push_req(exec_req(enc_i(OPC_LW, 5'd1, 5'd6, 16'h1000)));
        push_req(exec_req(enc_i(OPC_SW, 5'd1, 5'd2, 16'hFFFC)));
        push_req(exec_req(enc_i(OPC_ADDIU, 5'd0, 5'd7, 16'hFFFF)));
        push_req(exec_req(enc_r(FN_ADDU, 5'd7, 5'd7, 5'd8, 5'd0)));
        push_req(exec_req(enc_r(FN_SUBU, 5'd0, 5'd7, 5'd9, 5'd0)));
        push_req(exec_req(enc_r(FN_AND, 5'd7, 5'd9, 5'd10, 5'd0)));
        push_req(exec_req(enc_r(FN_OR, 5'd8, 5'd9, 5'd11, 5'd0)));
        push_req(exec_req(enc_r(FN_NOR, 5'd0, 5'd0, 5'd12, 5'd0)));
        push_req(exec_req(enc_r(FN_SLTU, 5'd9, 5'd7, 5'd13, 5'd0)));
        push_req(exec_req(enc_r(FN_SLL, 5'd0, 5'd7, 5'd14, 5'd31)));
        push_req(exec_req(enc_r(FN_SRL, 5'd0, 5'd7, 5'd15, 5'd31)));
        push_req(exec_req(enc_i(OPC_ANDI, 5'd7, 5'd16, 16'hFFFF)));
        push_req(exec_req(enc_i(OPC_SLTIU, 5'd9, 5'd17, 16'h8000)));
        push_req(exec_req(enc_i(OPC_ORI, 5'd7, 5'd0, 16'h1234)));
        push_req(exec_req(enc_i(OPC_BEQ, 5'd0, 5'd0, 16'hFFFF)));
        push_req(exec_req(enc_i(OPC_BNE, 5'd7, 5'd9, 16'h7FFF)));
        push_req(exec_req(enc_j(OPC_J, 26'h3FF_FFFF)));
        push_req(exec_req(enc_j(OPC_JAL, 26'h000_0000)));
        push_req(exec_req(enc_r(FN_JR, 5'd1, 5'd0, 5'd0, 5'd0)));
        push_req(exec_req(32'hFFFF_FFFF));
        push_req(exec_req(enc_r(6'h3F, 5'd7, 5'd7, 5'd20, 5'd0)));
        drain();

        write_cfg(REG_DATA_BASE, 32'h0000_0000);
        write_cfg(REG_START_PC, 32'h0000_0000);
        gen_phase(220);
        drain();

        send_idle <= 75;
        recv_idle <= 35;
        write_cfg(REG_DATA_BASE, 32'hFFFF_FFFF);
        write_cfg(REG_START_PC, 32'hFFFF_FFFF);
        gen_phase(200);
        drain();

        send_idle <= 0;
        recv_idle <= 0;
        write_cfg(REG_DATA_BASE, $urandom);
        write_cfg(REG_START_PC, $urandom);
        gen_phase(200);
        drain();

        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/mse_pkg.sv
hw/rtl/mse_out_fifo.sv
hw/rtl/mips_subset_execute.sv
bench/tb_mips_subset_execute.sv
